[design/npwr_pkg.sv]
package npwr_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int COORD_W  = 16;
	localparam int RADIUS_W = 15;
	localparam int INDEX_W  = 10;
	localparam int MAG_W    = 16;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int D2_W     = SQ_W + 1;
	localparam int R2_W     = 2 * RADIUS_W;
	localparam int ENTRY_W  = 2 * COORD_W;

	localparam logic [1:0] FUNC_APPEND = 2'd0;
	localparam logic [1:0] FUNC_QUERY  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd16;

	typedef logic [1:0]              func_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [RADIUS_W-1:0]     radius_t;
	typedef logic [INDEX_W-1:0]      index_t;
	typedef logic [ADDR_W-1:0]       addr_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [R2_W-1:0]         r2_t;
	typedef logic [ENTRY_W-1:0]      entry_t;

	typedef struct packed {
		logic  busy;
		logic  found;
		addr_t best_idx;
	} dist_status_t;

endpackage

[design/npwr_cmd_if.sv]
interface npwr_cmd_if;
	logic             valid;
	logic             ready;
	npwr_pkg::func_t  func;
	npwr_pkg::coord_t coord_x;
	npwr_pkg::coord_t coord_y;

	modport source (output valid, output func, output coord_x, output coord_y, input ready);
	modport sink (input valid, input func, input coord_x, input coord_y, output ready);
endinterface

[design/npwr_res_if.sv]
interface npwr_res_if;
	logic             valid;
	logic             ready;
	npwr_pkg::index_t matched_index;

	modport source (output valid, output matched_index, input ready);
	modport sink (input valid, input matched_index, output ready);
endinterface

[design/npwr_cfg_if.sv]
interface npwr_cfg_if;
	logic              valid;
	logic              ready;
	npwr_pkg::radius_t match_radius;

	modport source (output valid, output match_radius, input ready);
	modport sink (input valid, input match_radius, output ready);
endinterface

[design/npwr_ram.sv]
module npwr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/npwr_dist.sv]
module npwr_dist (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   issue_v,
	input  npwr_pkg::addr_t        issue_idx,
	input  npwr_pkg::entry_t       rdata,
	input  npwr_pkg::coord_t       qx,
	input  npwr_pkg::coord_t       qy,
	input  npwr_pkg::r2_t          r2,
	output npwr_pkg::dist_status_t status
);

	logic                         v_s1, v_s2, v_s3, v_s4;
	npwr_pkg::addr_t              idx_s1, idx_s2, idx_s3, idx_s4;
	logic [npwr_pkg::MAG_W-1:0]   mag_x_s2, mag_y_s2;
	logic [npwr_pkg::SQ_W-1:0]    sq_x_s3, sq_y_s3;
	logic [npwr_pkg::D2_W-1:0]    d2_s4;
	logic                         found_q;
	npwr_pkg::r2_t                best_q;
	npwr_pkg::addr_t              best_idx_q;

	npwr_pkg::coord_t             sx, sy;
	logic signed [npwr_pkg::COORD_W:0] dx, dy;
	logic [npwr_pkg::COORD_W:0]   ax, ay;
	logic                         hit;

	assign sx = rdata[npwr_pkg::ENTRY_W-1:npwr_pkg::COORD_W];
	assign sy = rdata[npwr_pkg::COORD_W-1:0];
	assign dx = {qx[npwr_pkg::COORD_W-1], qx} - {sx[npwr_pkg::COORD_W-1], sx};
	assign dy = {qy[npwr_pkg::COORD_W-1], qy} - {sy[npwr_pkg::COORD_W-1], sy};
	assign ax = dx[npwr_pkg::COORD_W] ? (~dx + 1'b1) : dx;
	assign ay = dy[npwr_pkg::COORD_W] ? (~dy + 1'b1) : dy;

	assign hit = v_s4
		&& (d2_s4 < {{(npwr_pkg::D2_W - npwr_pkg::R2_W){1'b0}}, r2})
		&& (!found_q || (d2_s4 < {{(npwr_pkg::D2_W - npwr_pkg::R2_W){1'b0}}, best_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= issue_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (start) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= issue_idx;
		idx_s2   <= idx_s1;
		mag_x_s2 <= ax[npwr_pkg::MAG_W-1:0];
		mag_y_s2 <= ay[npwr_pkg::MAG_W-1:0];
		idx_s3   <= idx_s2;
		sq_x_s3  <= mag_x_s2 * mag_x_s2;
		sq_y_s3  <= mag_y_s2 * mag_y_s2;
		idx_s4   <= idx_s3;
		d2_s4    <= {1'b0, sq_x_s3} + {1'b0, sq_y_s3};
		if (hit) begin
			best_q     <= d2_s4[npwr_pkg::R2_W-1:0];
			best_idx_q <= idx_s4;
		end
	end

	assign status.busy     = v_s1 | v_s2 | v_s3 | v_s4;
	assign status.found    = found_q;
	assign status.best_idx = best_idx_q;

endmodule

[design/nearest_point_within_radius.sv]
// channel  dir  payload                          transaction
// cfg      in   match_radius[14:0]               valid & ready, always ready
// cmd      in   func[1:0], coord_x, coord_y      valid & ready
// res      out  matched_index[9:0]               valid & ready
//
// Append and clear complete in the idle state. A query scans one table entry per cycle
// through the distance pipe, limited by the single read port of the point RAM.
// Reset clears entry count, radius (to 16) and all control; the RAM is not cleared.
// A result waiting on res does not block appends or clears; a further query
// holds its result until the previous one is taken.
module nearest_point_within_radius (
	input logic               clk,
	input logic               arst_n,
	npwr_cfg_if.sink          cfg,
	npwr_cmd_if.sink          cmd,
	npwr_res_if.source        res
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]             state_q;
	npwr_pkg::cnt_t         count_q;
	npwr_pkg::cnt_t         addr_q;
	npwr_pkg::radius_t      radius_q;
	npwr_pkg::r2_t          r2_q;
	npwr_pkg::coord_t       qx_q, qy_q;
	logic                   res_valid_q;
	npwr_pkg::index_t       res_idx_q;

	logic                   cmd_acc;
	logic                   we;
	logic                   issue;
	logic                   start;
	npwr_pkg::r2_t          r2_next;
	npwr_pkg::entry_t       rdata;
	npwr_pkg::dist_status_t st;
	logic [npwr_pkg::ADDR_W+npwr_pkg::INDEX_W-1:0] idx_ext;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign we        = cmd_acc && (cmd.func == npwr_pkg::FUNC_APPEND)
		&& (count_q < npwr_pkg::cnt_t'(npwr_pkg::TABLE_DEPTH));
	assign start     = cmd_acc && (cmd.func == npwr_pkg::FUNC_QUERY);
	assign issue     = (state_q == ST_SCAN) && (addr_q < count_q);
	assign r2_next   = npwr_pkg::r2_t'(radius_q) * npwr_pkg::r2_t'(radius_q);
	assign idx_ext   = {{npwr_pkg::INDEX_W{1'b0}}, st.best_idx};

	assign res.valid         = res_valid_q;
	assign res.matched_index = res_idx_q;

	npwr_ram #(
		.WIDTH (npwr_pkg::ENTRY_W),
		.DEPTH (npwr_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[npwr_pkg::ADDR_W-1:0]),
		.wdata ({cmd.coord_x, cmd.coord_y}),
		.re    (issue),
		.raddr (addr_q[npwr_pkg::ADDR_W-1:0]),
		.rdata (rdata)
	);

	npwr_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.issue_v   (issue),
		.issue_idx (addr_q[npwr_pkg::ADDR_W-1:0]),
		.rdata     (rdata),
		.qx        (qx_q),
		.qy        (qy_q),
		.r2        (r2_q),
		.status    (st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			addr_q      <= '0;
			radius_q    <= npwr_pkg::RADIUS_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				radius_q <= cfg.match_radius;
			end
			if (res.valid && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (we) begin
						count_q <= count_q + 1'b1;
					end
					if (cmd_acc && (cmd.func == npwr_pkg::FUNC_CLEAR)) begin
						count_q <= '0;
					end
					if (start) begin
						addr_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						addr_q <= addr_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!st.busy) begin
						state_q <= st.found ? ST_OUT : ST_IDLE;
					end
				end
				ST_OUT: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			qx_q <= cmd.coord_x;
			qy_q <= cmd.coord_y;
			r2_q <= r2_next;
		end
		if ((state_q == ST_OUT) && (!res_valid_q || res.ready)) begin
			res_idx_q <= idx_ext[npwr_pkg::INDEX_W-1:0];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= npwr_pkg::cnt_t'(npwr_pkg::TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_res_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside output state");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !st.busy)
		else $error("distance pipe busy while idle");

	a_out_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> st.found)
		else $error("output state without a match");

endmodule
